// ===== sv/q16alu_pkg.sv =====
package q16alu_pkg;

	// Operation codes carried on the action field.
	typedef enum logic [2:0] {
		OP_FROM_INT = 3'd0,
		OP_TO_INT   = 3'd1,
		OP_ADD      = 3'd2,
		OP_SUB      = 3'd3,
		OP_MUL      = 3'd4,
		OP_DIV      = 3'd5,
		OP_ABS      = 3'd6,
		OP_CLAMP    = 3'd7
	} op_t;

	localparam int FRAC_BITS  = 16;
	localparam int DIV_STEPS  = 32;
	localparam int INT_IN_HI  = 32767;
	localparam int INT_IN_LO  = -32768;

	localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN      = 32'h8000_0000;
	localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0000_8000;

	// Per-item payload that moves down the pipeline.
	// For mul, {rem, sh} holds the 64-bit magnitude product.
	// For div, rem is the partial remainder, sh shifts dividend bits out
	// and quotient bits in, and dvs is the divisor magnitude.
	typedef struct packed {
		op_t         op;
		logic        neg;
		logic        sat;
		logic [31:0] rem;
		logic [31:0] sh;
		logic [31:0] dvs;
		logic [31:0] res;
	} stage_t;

endpackage

// ===== sv/q16_saturating_alu.sv =====
// Signed Q16.16 saturating ALU.
// Command channel: cmd_valid / cmd_stall carry action, operand_a, operand_b and
// operand_c. A transaction takes place at a rising edge with cmd_valid high
// and cmd_stall low. Response channel: rsp_valid / rsp_stall carry result,
// with the same rule; every command gives exactly one response, in order.
// Throughput is one command per cycle while cmd_stall is low. The pipeline
// runs from the command transaction to rsp_valid through one input stage,
// one multiply stage, one rounding stage, 32 divider stages that each resolve
// one quotient bit, and one saturation stage. Every operation takes the same
// path length, so results leave in order. The divider chain sets the depth.
// When the receiver stalls, the result in the last stage is moved into a
// skid register and the pipeline takes one more step; then the whole
// pipeline holds and cmd_stall stays high until the skid register empties.
// Reset (arst_n low) clears all valid bits and the skid-full flag; items in
// flight are dropped.
module q16_saturating_alu
	import q16alu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic signed [31:0] operand_c,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] result
);

	logic        en;
	logic        skid_full_q;
	logic [31:0] skid_q;

	stage_t      st_s1, st_s2, st_s3;
	logic        vld_s1, vld_s2, vld_s3;
	stage_t      div_s     [DIV_STEPS];
	logic        div_vld_s [DIV_STEPS];
	logic [31:0] res_s36;
	logic        vld_s36;

	// The pipeline moves as a whole whenever the skid register is empty.
	assign en        = !skid_full_q;
	assign cmd_stall = skid_full_q;

	// Input decode and the operations that are resolved in the input stage.
	op_t                op_in;
	logic        [31:0] a_mag, b_mag;
	logic signed [31:0] a_shr;
	logic        [31:0] to_int_res;
	logic        [32:0] sum33, dif33;
	stage_t             st_in;

	assign op_in      = op_t'(action);
	assign a_mag      = operand_a[31] ? 32'(-operand_a) : operand_a;
	assign b_mag      = operand_b[31] ? 32'(-operand_b) : operand_b;
	assign a_shr      = operand_a >>> FRAC_BITS;
	assign to_int_res = a_shr + {31'b0, operand_a[31] & (|operand_a[FRAC_BITS-1:0])};
	assign sum33      = {operand_a[31], operand_a} + {operand_b[31], operand_b};
	assign dif33      = {operand_a[31], operand_a} - {operand_b[31], operand_b};

	always_comb begin
		st_in     = '0;
		st_in.op  = op_in;
		st_in.sh  = a_mag;
		st_in.dvs = b_mag;
		unique case (op_in)
			OP_FROM_INT: begin
				if (operand_a > INT_IN_HI) begin
					st_in.res = Q_MAX;
				end else if (operand_a < INT_IN_LO) begin
					st_in.res = Q_MIN;
				end else begin
					st_in.res = {operand_a[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
				end
			end
			OP_TO_INT: begin
				st_in.res = to_int_res;
			end
			OP_ADD: begin
				if (sum33[32] != sum33[31]) begin
					st_in.res = sum33[32] ? Q_MIN : Q_MAX;
				end else begin
					st_in.res = sum33[31:0];
				end
			end
			OP_SUB: begin
				if (dif33[32] != dif33[31]) begin
					st_in.res = dif33[32] ? Q_MIN : Q_MAX;
				end else begin
					st_in.res = dif33[31:0];
				end
			end
			OP_MUL: begin
				st_in.neg = operand_a[31] ^ operand_b[31];
			end
			OP_DIV: begin
				// Division by zero saturates by the sign of the dividend.
				if (operand_b == '0) begin
					st_in.sat = 1'b1;
					st_in.neg = operand_a[31];
				end else begin
					st_in.neg = operand_a[31] ^ operand_b[31];
				end
			end
			OP_ABS: begin
				st_in.res = (operand_a == Q_MIN) ? Q_MAX : a_mag;
			end
			OP_CLAMP: begin
				if (operand_b > operand_c) begin
					st_in.res = operand_b;
				end else if (operand_a < operand_b) begin
					st_in.res = operand_b;
				end else if (operand_a > operand_c) begin
					st_in.res = operand_c;
				end else begin
					st_in.res = operand_a;
				end
			end
			default: begin
				st_in.res = '0;
			end
		endcase
	end

	// Stage 2: magnitude product for mul, dividend setup and overflow check for div.
	stage_t st_nx2;

	always_comb begin
		st_nx2 = st_s1;
		if (st_s1.op == OP_MUL) begin
			{st_nx2.rem, st_nx2.sh} = {32'b0, st_s1.sh} * {32'b0, st_s1.dvs};
		end else if (st_s1.op == OP_DIV) begin
			st_nx2.rem = {16'b0, st_s1.sh[31:FRAC_BITS]};
			st_nx2.sh  = {st_s1.sh[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			// A quotient of 2**32 or more cannot be represented.
			st_nx2.sat = st_s1.sat | ({16'b0, st_s1.sh[31:FRAC_BITS]} >= st_s1.dvs);
		end
	end

	// Stage 3: rounding for mul, half away from zero on the magnitude.
	stage_t st_nx3;

	always_comb begin
		st_nx3 = st_s2;
		if (st_s2.op == OP_MUL) begin
			{st_nx3.rem, st_nx3.sh} = {st_s2.rem, st_s2.sh} + ROUND_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_in;
			st_s2 <= st_nx2;
			st_s3 <= st_nx3;
		end
	end

	// Restoring divider: each stage resolves one quotient bit.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		stage_t      prv;
		stage_t      nxt;
		logic        prv_vld;
		logic [32:0] trial;

		if (k == 0) begin : g_first
			assign prv     = st_s3;
			assign prv_vld = vld_s3;
		end else begin : g_next
			assign prv     = div_s[k-1];
			assign prv_vld = div_vld_s[k-1];
		end

		assign trial = {prv.rem, prv.sh[31]} - {1'b0, prv.dvs};

		always_comb begin
			nxt = prv;
			if (prv.op == OP_DIV) begin
				if (!trial[32]) begin
					nxt.rem = trial[31:0];
				end else begin
					nxt.rem = {prv.rem[30:0], prv.sh[31]};
				end
				nxt.sh = {prv.sh[30:0], !trial[32]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (en) begin
				div_vld_s[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end
	end

	// Final stage: apply the sign and saturate mul and div results.
	stage_t      st_last;
	logic [47:0] mag48;
	logic        over;
	logic [31:0] res_nx;

	assign st_last = div_s[DIV_STEPS-1];

	always_comb begin
		if (st_last.op == OP_MUL) begin
			mag48 = {st_last.rem, st_last.sh[31:FRAC_BITS]};
		end else begin
			mag48 = {16'b0, st_last.sh};
		end
		over = st_last.sat |
			(st_last.neg ? (mag48 > 48'h0000_8000_0000) : (mag48 > 48'h0000_7FFF_FFFF));
		if (st_last.op == OP_MUL || st_last.op == OP_DIV) begin
			if (over) begin
				res_nx = st_last.neg ? Q_MIN : Q_MAX;
			end else if (st_last.neg) begin
				res_nx = 32'(-mag48[31:0]);
			end else begin
				res_nx = mag48[31:0];
			end
		end else begin
			res_nx = st_last.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s36 <= 1'b0;
		end else if (en) begin
			vld_s36 <= div_vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s36 <= res_nx;
		end
	end

	// Skid register holds a stalled result so the last stage can move on once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q) begin
			if (vld_s36 && rsp_stall) begin
				skid_full_q <= 1'b1;
			end
		end else if (!rsp_stall) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld_s36 && rsp_stall) begin
			skid_q <= res_s36;
		end
	end

	assign rsp_valid = skid_full_q || vld_s36;
	assign result    = skid_full_q ? skid_q : res_s36;

	// A stalled result in the last stage must land in the skid register.
	a_skid_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s36 && rsp_stall && !skid_full_q) |=> (skid_full_q && skid_q == $past(res_s36)))
		else $error("stalled result was not captured by the skid register");

	// A zero divisor must always be flagged for saturation.
	a_div_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_s[DIV_STEPS-1] && st_last.op == OP_DIV && st_last.dvs == '0) |-> st_last.sat)
		else $error("division by zero reached the last stage unsaturated");

	// The final partial remainder of a valid division stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_s[DIV_STEPS-1] && st_last.op == OP_DIV && !st_last.sat)
		|-> (st_last.rem < st_last.dvs))
		else $error("divider remainder not below divisor");

endmodule

// ===== tb/alu_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the Q16.16 ALU, predicts each result from the
// accepted command and compares it with the response that comes out.
module alu_checker
	import q16alu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic signed [31:0] operand_c,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [31:0] result,
	output int                 mismatches,
	output int                 outstanding
);

	localparam longint SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SAT_LO    = -64'sh0000_0000_8000_0000;
	localparam longint ONE_Q     = 64'sh0000_0000_0001_0000;
	localparam longint HALF_LSB  = 64'sh0000_0000_0000_8000;
	localparam int     MAX_SHOWN = 10;

	// One command waiting for its response.
	typedef struct {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] value;
	} alu_result_t;

	alu_result_t result_queue[$];
	int error_total = 0;

	// Clip a wide intermediate to the 32-bit signed range.
	function automatic longint clip32(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// Exact Q16.16 result of one command, worked out in 64-bit arithmetic.
	function automatic logic signed [31:0] q16_compute(op_t op, logic signed [31:0] a,
		logic signed [31:0] b, logic signed [31:0] c);
		longint wa;
		longint wb;
		longint wc;
		longint prod;
		longint r;
		wa = a;
		wb = b;
		wc = c;
		case (op)
			OP_FROM_INT: begin
				if (wa > INT_IN_HI)
					r = SAT_HI;
				else if (wa < INT_IN_LO)
					r = SAT_LO;
				else
					r = wa * ONE_Q;
			end
			OP_TO_INT: r = wa / ONE_Q;
			OP_ADD:    r = clip32(wa + wb);
			OP_SUB:    r = clip32(wa - wb);
			OP_MUL: begin
				// Round half away from zero before dropping the fraction.
				prod = wa * wb;
				if (prod >= 0)
					prod = prod + HALF_LSB;
				else
					prod = prod - HALF_LSB;
				r = clip32(prod / ONE_Q);
			end
			OP_DIV: begin
				// A zero divisor saturates toward the sign of the dividend.
				if (wb == 0)
					r = (wa >= 0) ? SAT_HI : SAT_LO;
				else
					r = clip32((wa * ONE_Q) / wb);
			end
			OP_ABS: begin
				if (wa == SAT_LO)
					r = SAT_HI;
				else if (wa < 0)
					r = -wa;
				else
					r = wa;
			end
			default: begin
				// Inverted bounds give the lower bound whatever the value.
				if (wb > wc)
					r = wb;
				else if (wa < wb)
					r = wb;
				else if (wa > wc)
					r = wc;
				else
					r = wa;
			end
		endcase
		return r[31:0];
	endfunction

	// Retire responses against the oldest prediction, then record new commands.
	always @(posedge clk or negedge arst_n) begin
		alu_result_t want;
		alu_result_t entry;
		if (!arst_n) begin
			result_queue.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (result_queue.size() == 0) begin
					error_total++;
					if (error_total <= MAX_SHOWN)
						$display("%0t: response %h arrived with no command pending",
							$realtime, result);
				end else begin
					want = result_queue.pop_front();
					if (result !== want.value) begin
						error_total++;
						if (error_total <= MAX_SHOWN)
							$display("%0t: %s a=%h b=%h c=%h: expected %h, got %h",
								$realtime, want.op.name(), want.a, want.b, want.c,
								want.value, result);
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				entry.op    = op_t'(action);
				entry.a     = operand_a;
				entry.b     = operand_b;
				entry.c     = operand_c;
				entry.value = q16_compute(op_t'(action), operand_a, operand_b, operand_c);
				result_queue.push_back(entry);
			end
			outstanding <= result_queue.size();
			mismatches  <= error_total;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Drives random and directed commands into the Q16.16 ALU with idle and
// stall patterns on both channels; the checker beside the block judges them.
module testbench
	import q16alu_pkg::*;
();

	localparam int RANDOM_PER_PHASE = 600;
	localparam int HOLD_CYCLES      = 200;
	localparam int SETTLE_CYCLES    = 50;
	localparam int CYCLE_LIMIT      = 300000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic [2:0]         action    = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic signed [31:0] operand_c = '0;
	logic               rsp_stall = 1'b0;
	logic               cmd_stall;
	logic               rsp_valid;
	logic signed [31:0] result;

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int holds_asked   = 0;
	int holds_done    = 0;
	int hold_count    = 0;
	int cycle_count   = 0;

	q16_saturating_alu u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.operand_c (operand_c),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.result    (result)
	);

	alu_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.action      (action),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.operand_c   (operand_c),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Response side: random stalls, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				if (hold_count < HOLD_CYCLES) begin
					rsp_stall <= 1'b1;
					hold_count++;
				end else begin
					rsp_stall <= 1'b0;
					hold_count = 0;
					holds_done++;
				end
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Offer one command, with random idle cycles before it, and wait for its transaction.
	task automatic send_op(input op_t op, input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		action    <= op;
		operand_a <= a;
		operand_b <= b;
		operand_c <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// Stop offering commands until every response has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Operand mix: extremes, small values, whole numbers, pure fractions, full range.
	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(9))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2:       return '0;
			3:       return Q_MAX - 32'($urandom_range(255));
			4:       return Q_MIN + 32'($urandom_range(255));
			5:       return 32'($urandom_range(32'h0006_0000)) - 32'h0003_0000;
			6:       return {16'($urandom), 16'h0000};
			7:       return 32'($urandom_range(32'h0001_FFFF)) - 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	// Random commands, shaped per operation toward its boundaries.
	task automatic run_random(input int count);
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] swap;
		int                 edge_v;
		repeat (count) begin
			op = op_t'($urandom_range(7));
			a  = rand_q16();
			b  = rand_q16();
			c  = rand_q16();
			case (op)
				OP_FROM_INT: begin
					if ($urandom_range(1)) begin
						edge_v = $urandom_range(1) ? INT_IN_HI : INT_IN_LO;
						a = edge_v + int'($urandom_range(8)) - 4;
					end
				end
				OP_DIV: begin
					if ($urandom_range(7) == 0)
						b = '0;
				end
				OP_CLAMP: begin
					// Mostly ordered bounds, some inverted ones.
					if ($urandom_range(4) != 0 && b > c) begin
						swap = b;
						b    = c;
						c    = swap;
					end
				end
				default: ;
			endcase
			send_op(op, a, b, c);
		end
	endtask

	// Main sequence: reset, directed cases, then three idle profiles.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed boundaries and special cases.
		send_op(OP_FROM_INT, 32'sd32767, $urandom, $urandom);
		send_op(OP_FROM_INT, 32'sd32768, $urandom, $urandom);
		send_op(OP_FROM_INT, -32'sd32768, $urandom, $urandom);
		send_op(OP_FROM_INT, -32'sd32769, $urandom, $urandom);
		send_op(OP_TO_INT, -32'sd1, $urandom, $urandom);
		send_op(OP_TO_INT, -32'sd98304, $urandom, $urandom);
		send_op(OP_TO_INT, Q_MIN, $urandom, $urandom);
		send_op(OP_TO_INT, Q_MAX, $urandom, $urandom);
		send_op(OP_ADD, Q_MAX, 32'sd1, $urandom);
		send_op(OP_ADD, Q_MIN, -32'sd1, $urandom);
		send_op(OP_SUB, Q_MIN, 32'sd1, $urandom);
		send_op(OP_SUB, Q_MAX, -32'sd1, $urandom);
		send_op(OP_MUL, Q_MAX, Q_MAX, $urandom);
		send_op(OP_MUL, Q_MIN, Q_MAX, $urandom);
		send_op(OP_MUL, 32'sh0000_8000, 32'sd1, $urandom);
		send_op(OP_MUL, -32'sh0000_8000, 32'sd1, $urandom);
		send_op(OP_DIV, 32'sd0, 32'sd0, $urandom);
		send_op(OP_DIV, -32'sd5, 32'sd0, $urandom);
		send_op(OP_DIV, Q_MIN, -32'sd1, $urandom);
		send_op(OP_DIV, 32'sh0003_0000, -32'sh0002_0000, $urandom);
		send_op(OP_ABS, Q_MIN, $urandom, $urandom);
		send_op(OP_ABS, -32'sd5, $urandom, $urandom);
		send_op(OP_CLAMP, 32'sd0, 32'sd10, -32'sd10);
		send_op(OP_CLAMP, Q_MIN, -32'sd10, 32'sd10);
		send_op(OP_CLAMP, Q_MAX, -32'sd10, 32'sd10);
		send_op(OP_CLAMP, 32'sd3, -32'sd10, 32'sd10);
		drain();

		// Sender nearly always busy, receiver mostly stalled.
		send_idle_pct = 7;
		rsp_stall_pct = 84;
		run_random(RANDOM_PER_PHASE);
		drain();

		// Sender mostly idle, receiver rarely stalled.
		send_idle_pct = 84;
		rsp_stall_pct = 7;
		run_random(RANDOM_PER_PHASE);
		drain();

		// No idling; a long receiver hold-off fills the pipeline first.
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		holds_asked++;
		run_random(RANDOM_PER_PHASE);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/q16alu_pkg.sv
sv/q16_saturating_alu.sv
tb/alu_checker.sv
tb/testbench.sv
